/* sv/gaps_pkg.sv */
// Shared constants, field layout and controller/datapath interface types for parent selection.
package gaps_pkg;

    // Fixed field widths
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int FIT_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Stream payload layout
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;
    localparam int ENTRY_LSB   = 0;
    localparam int FIT_LSB     = ENTRY_LSB + IDX_W;
    localparam int FRAC_LSB    = FIT_LSB + FIT_W;
    localparam int RAND_LSB    = FRAC_LSB + FRAC_W;

    // Stop-point multiply, one digit of the fraction per cycle
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = FRAC_W / DIGIT_W;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

    localparam logic FUNC_WRITE      = 1'b0;
    localparam logic FUNC_DRAW       = 1'b1;
    localparam logic MODE_ROULETTE   = 1'b0;
    localparam logic MODE_TOURNAMENT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUR_SIZE = 2'd2;

    localparam logic [CNT_W-1:0] POP_SIZE_RESET  = 7'd64;
    localparam logic [CNT_W-1:0] TOUR_SIZE_RESET = 7'd2;
    localparam logic [CNT_W-1:0] POP_MIN         = 7'd2;
    localparam logic [CNT_W-1:0] PARENT_SPAN     = 7'd64;

    typedef struct packed {
        logic load_in;
        logic write_entry;
        logic rd_last;
        logic rd_zero;
        logic rd_cand;
        logic issue;
        logic cap_last;
        logic clr_total;
        logic walk_clr;
        logic acc_sum;
        logic total_done;
        logic mul_step;
        logic acc_walk;
        logic tour_init;
        logic tour_cmp;
        logic push;
    } t_gaps_cmd;

    typedef struct packed {
        logic func;
        logic mode;
        logic stale;
        logic tour_first;
        logic tour_done;
        logic issue_last;
        logic mul_last;
        logic out_busy;
    } t_gaps_status;

endpackage

/* sv/gaps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gaps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gaps_ctrl.sv */
// Sequencing state machine for writes, roulette draws and tournament draws.
module gaps_ctrl import gaps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_gaps_status i_status,
    output logic         o_in_ready,
    output t_gaps_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_LAST     = 4'd2;
    localparam logic [3:0] ST_SUM      = 4'd3;
    localparam logic [3:0] ST_SUM_END  = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_WALK     = 4'd6;
    localparam logic [3:0] ST_WALK_END = 4'd7;
    localparam logic [3:0] ST_T_INIT   = 4'd8;
    localparam logic [3:0] ST_T_CMP    = 4'd9;
    localparam logic [3:0] ST_RESULT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.func == FUNC_WRITE) begin
                    o_cmd.write_entry = 1'b1;
                    n_state           = ST_IDLE;
                end else if (i_status.mode == MODE_ROULETTE) begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = ST_LAST;
                end else if (i_status.tour_first) begin
                    o_cmd.rd_zero = 1'b1;
                    n_state       = ST_T_INIT;
                end else begin
                    o_cmd.rd_cand = 1'b1;
                    n_state       = ST_T_CMP;
                end
            end
            ST_LAST: begin
                o_cmd.cap_last  = 1'b1;
                o_cmd.walk_clr  = 1'b1;
                o_cmd.clr_total = i_status.stale;
                n_state         = i_status.stale ? ST_SUM : ST_MUL;
            end
            ST_SUM: begin
                o_cmd.issue   = 1'b1;
                o_cmd.acc_sum = 1'b1;
                if (i_status.issue_last) begin
                    n_state = ST_SUM_END;
                end
            end
            ST_SUM_END: begin
                o_cmd.acc_sum    = 1'b1;
                o_cmd.total_done = 1'b1;
                o_cmd.walk_clr   = 1'b1;
                n_state          = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.issue    = 1'b1;
                o_cmd.acc_walk = 1'b1;
                if (i_status.issue_last) begin
                    n_state = ST_WALK_END;
                end
            end
            ST_WALK_END: begin
                o_cmd.acc_walk = 1'b1;
                n_state        = ST_RESULT;
            end
            ST_T_INIT: begin
                o_cmd.tour_init = 1'b1;
                o_cmd.rd_cand   = 1'b1;
                n_state         = ST_T_CMP;
            end
            ST_T_CMP: begin
                o_cmd.tour_cmp = 1'b1;
                n_state        = i_status.tour_done ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                // hold until the output register can take the result
                if (!i_status.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_result_is_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT) |-> (i_status.func == FUNC_DRAW))
        else $error("result stage reached for a write request");

    a_walk_total_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> !i_status.stale)
        else $error("roulette walk started on a stale total");

    a_sum_clears_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM_END) |=> !i_status.stale)
        else $error("total rebuild did not clear the stale flag");

endmodule

/* sv/gaps_dp.sv */
// Datapath: fitness table, roulette total and walk, tournament tracking, pair logic, output register.
module gaps_dp import gaps_pkg::*; #(
    parameter int POP_DEPTH    = 64,
    parameter int FITNESS_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_user,
    input  t_gaps_cmd              i_cmd,
    output t_gaps_status           o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_user
);

    localparam int IW = $clog2(POP_DEPTH);
    localparam int DW = FITNESS_BITS + 1;
    localparam int TW = FITNESS_BITS + 8;
    localparam int SW = TW + 1;
    localparam int PW = TW + FRAC_W + 1;

    // Configuration
    logic                 r_mode;
    logic [CNT_W-1:0]     r_pop;
    logic [CNT_W-1:0]     r_tour;

    // Captured request
    logic                 r_func;
    logic [IDX_W-1:0]     r_entry;
    logic [FIT_W-1:0]     r_fit;
    logic [FRAC_W-1:0]    r_frac;
    logic [IDX_W-1:0]     r_rand;

    // Table walk
    logic [CNT_W-1:0]        r_idx;
    logic                    r_rv;
    logic [CNT_W-1:0]        r_rv_idx;
    logic signed [FITNESS_BITS-1:0] r_last;
    logic signed [TW-1:0]    r_total;
    logic                    r_stale;
    logic signed [TW-1:0]    r_cum;
    logic                    r_found;
    logic [CNT_W-1:0]        r_found_idx;
    logic [MUL_CNT_W-1:0]    r_mul_cnt;
    logic signed [PW-1:0]    r_prod;

    // Tournament
    logic [CNT_W-1:0]        r_tcount;
    logic [CNT_W-1:0]        r_best_idx;
    logic signed [FITNESS_BITS-1:0] r_best_fit;

    // Pairing and output
    logic                    r_phase;
    logic [IDX_W-1:0]        r_first;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_second;

    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_n_m1;
    logic [CNT_W-1:0]        w_cand;
    logic [CNT_W-1:0]        w_need;
    logic [CNT_W-1:0]        w_tcount_inc;
    logic [IW-1:0]           w_raddr;
    logic                    w_we;
    logic [63:0]             w_fit_wide;
    logic signed [FITNESS_BITS-1:0] w_rdata;
    logic signed [DW-1:0]    w_term;
    logic signed [TW-1:0]    w_sum_next;
    logic signed [TW-1:0]    w_cum_next;
    logic signed [SW-1:0]    w_stop;
    logic                    w_hit;
    logic [FRAC_W-1:0]       w_frac_sh;
    logic [DIGIT_W-1:0]      w_digit;
    logic signed [TW+DIGIT_W:0] w_pp;
    logic [CNT_W-1:0]        w_pick;
    logic [CNT_W-1:0]        w_pick2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ROULETTE;
            r_pop  <= POP_SIZE_RESET;
            r_tour <= TOUR_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:      r_mode <= i_cfg_data[0];
                CFG_POP_SIZE:  r_pop  <= i_cfg_data;
                CFG_TOUR_SIZE: r_tour <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Entries in use, clamped to [2, POP_DEPTH]
    always_comb begin
        if (r_pop < POP_MIN) begin
            w_n = POP_MIN;
        end else if (int'(r_pop) > POP_DEPTH) begin
            w_n = CNT_W'(POP_DEPTH);
        end else begin
            w_n = r_pop;
        end
    end
    assign w_n_m1 = w_n - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_in_user;
            r_entry <= i_in_data[ENTRY_LSB +: IDX_W];
            r_fit   <= i_in_data[FIT_LSB +: FIT_W];
            r_frac  <= i_in_data[FRAC_LSB +: FRAC_W];
            r_rand  <= i_in_data[RAND_LSB +: IDX_W];
        end
    end

    assign w_cand = (CNT_W'(r_rand) >= w_n) ? w_n_m1 : CNT_W'(r_rand);

    always_comb begin
        priority if (i_cmd.rd_last) begin
            w_raddr = IW'(w_n_m1);
        end else if (i_cmd.rd_zero) begin
            w_raddr = '0;
        end else if (i_cmd.rd_cand) begin
            w_raddr = IW'(w_cand);
        end else begin
            w_raddr = IW'(r_idx);
        end
    end

    assign w_we       = i_cmd.write_entry && (int'(r_entry) < POP_DEPTH);
    assign w_fit_wide = 64'(r_fit);

    gaps_ram #(
        .WIDTH (FITNESS_BITS),
        .DEPTH (POP_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(r_entry)),
        .i_wdata (w_fit_wide[FITNESS_BITS-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Slot weight of the entry arriving from the table: last - f[i]
    assign w_term     = DW'(r_last) - DW'(w_rdata);
    assign w_sum_next = r_total + TW'(w_term);
    assign w_cum_next = r_cum + TW'(w_term);
    assign w_stop     = r_prod[PW-1:FRAC_W];
    assign w_hit      = SW'(w_cum_next) > w_stop;

    assign w_frac_sh = r_frac << (DIGIT_W * r_mul_cnt);
    assign w_digit   = w_frac_sh[FRAC_W-1 -: DIGIT_W];
    assign w_pp      = r_total * $signed({1'b0, w_digit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 1'b1;
            r_rv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_rv <= i_cmd.issue;
            if (w_we || (i_cfg_we && i_cfg_index == CFG_POP_SIZE)) begin
                r_stale <= 1'b1;
            end else if (i_cmd.total_done) begin
                r_stale <= 1'b0;
            end
            if (i_cmd.walk_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.acc_walk && r_rv && !r_found && w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv_idx <= r_idx;
        if (i_cmd.cap_last) begin
            r_last <= w_rdata;
        end
        if (i_cmd.walk_clr) begin
            r_idx     <= '0;
            r_cum     <= '0;
            r_mul_cnt <= '0;
            r_prod    <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.mul_step) begin
                // most significant digit first
                r_prod    <= (r_prod <<< DIGIT_W) + PW'(w_pp);
                r_mul_cnt <= r_mul_cnt + MUL_CNT_W'(1);
            end
            if (i_cmd.acc_walk && r_rv && !r_found) begin
                r_cum <= w_cum_next;
                if (w_hit) begin
                    r_found_idx <= r_rv_idx;
                end
            end
        end
        if (i_cmd.clr_total) begin
            r_total <= '0;
        end else if (i_cmd.acc_sum && r_rv) begin
            r_total <= w_sum_next;
        end
    end

    // Tournament: entry 0 is the incumbent, strictly lower fitness wins
    assign w_need       = (r_tour == '0) ? CNT_W'(1) : r_tour;
    assign w_tcount_inc = r_tcount + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount <= '0;
        end else if (i_cmd.tour_cmp) begin
            r_tcount <= (w_tcount_inc >= w_need) ? '0 : w_tcount_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tour_init) begin
            r_best_idx <= '0;
            r_best_fit <= w_rdata;
        end else if (i_cmd.tour_cmp && (w_rdata < r_best_fit)) begin
            r_best_idx <= w_cand;
            r_best_fit <= w_rdata;
        end
    end

    // Pair handling: second parent steps off the first
    assign w_pick = (r_mode == MODE_TOURNAMENT) ? r_best_idx :
                    (r_found ? r_found_idx : '0);

    always_comb begin
        w_pick2 = w_pick;
        if (w_pick == CNT_W'(r_first)) begin
            if (CNT_W'(r_first) != w_n_m1) begin
                w_pick2 = CNT_W'(r_first) + CNT_W'(1);
            end else begin
                w_pick2 = CNT_W'(r_first) - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
            r_phase     <= !r_phase;
            if (!r_phase) begin
                r_first <= w_pick[IDX_W-1:0];
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_idx    <= r_phase ? w_pick2[IDX_W-1:0] : w_pick[IDX_W-1:0];
            r_out_second <= r_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TDATA_W'(r_out_idx);
    assign o_out_user  = r_out_second;

    assign o_status.func       = r_func;
    assign o_status.mode       = r_mode;
    assign o_status.stale      = r_stale;
    assign o_status.tour_first = (r_tcount == '0);
    assign o_status.tour_done  = (w_tcount_inc >= w_need);
    assign o_status.issue_last = (r_idx == w_n_m1);
    assign o_status.mul_last   = (r_mul_cnt == MUL_CNT_W'(MUL_DIGITS - 1));
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !(r_out_valid && !i_out_ready))
        else $error("result pushed over an unaccepted result");

    a_roulette_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && r_mode == MODE_ROULETTE && r_found) |-> (r_found_idx < w_n))
        else $error("roulette pick beyond entries in use");

    a_pair_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && r_phase && w_n <= PARENT_SPAN) |=> (r_out_idx != r_first))
        else $error("second parent equals first parent");

endmodule

/* sv/ga_parent_selection_core.sv */
// Parent selection core for a genetic algorithm: roulette wheel or tournament over a fitness table.
//
// Input requests arrive on s_axis; s_axis_tuser selects a table write (0) or a draw (1).
// Results leave on m_axis as a parent index with a flag in m_axis_tuser marking the second
// parent of a pair. Writes and incomplete tournament draws produce no result.
// Configuration (mode, pop_size, tournament_size) is written through i_cfg_* while idle.
// One request is processed at a time; s_axis_tready is high only between requests.
// Request kinds: table write; tournament draw; roulette draw with the total current,
// which walks the table with one table read per cycle; roulette draw after a write or
// pop_size change, where the total is rebuilt first by a second pass over the table.
// The table memory has one read port, which bounds the walk to one entry per cycle.
// The result sits in an output register; while m_axis_tready is low the core finishes
// the next request up to its result and then holds.
// Reset clears the pair phase, tournament progress and configuration (roulette, 64, 2);
// table contents are undefined until written.
module ga_parent_selection_core import gaps_pkg::*; #(
    parameter int POP_DEPTH    = 64,
    parameter int FITNESS_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index[5:0], fitness_value[37:6], rand_fraction[53:38], rand_index[59:54]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // parent_index[5:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // second_of_pair[0]
    output logic [0:0]             m_axis_tuser
);

    t_gaps_cmd    w_cmd;
    t_gaps_status w_status;

    gaps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    gaps_dp #(
        .POP_DEPTH    (POP_DEPTH),
        .FITNESS_BITS (FITNESS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser[0]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser[0])
    );

endmodule
